// ===== rtl/core/ldip_pkg.sv =====
package ldip_pkg;

	localparam int MOD_WIDTH_DEFAULT    = 32;
	localparam int PLAIN_WIDTH          = 9;
	localparam int MSG_WIDTH            = 8;
	localparam int CFG_INDEX_WIDTH      = 2;
	localparam int CIPHER_MODULUS_RESET = 1024;
	localparam int PLAIN_MODULUS_RESET  = 4;
	localparam int PLAIN_MODULUS_MIN    = 2;
	localparam int PLAIN_MODULUS_MAX    = 256;
	localparam int CIPHER_MODULUS_MIN   = 2;
	localparam int CMD_DEPTH            = 2;
	localparam int RES_DEPTH            = 2;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_CIPHER_MODULUS = 2'd0,
		CFG_PLAIN_MODULUS  = 2'd1,
		CFG_NAND_MODE      = 2'd2
	} ldip_cfg_index_t;

	// per-request classification made by the front part
	typedef struct packed {
		logic last;
		logic mask_big;
		logic body_big;
	} ldip_flags_t;

endpackage

// ===== rtl/core/ldip_fifo.sv =====
module ldip_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] ptr);
		return (ptr == PtrW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			unique case ({do_wr, do_rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/ldip_front.sv =====
module ldip_front #(
	parameter int MOD_WIDTH = ldip_pkg::MOD_WIDTH_DEFAULT
) (
	input  logic                   push,
	output logic                   full,
	input  logic [MOD_WIDTH-1:0]   mask_coef,
	input  logic [MOD_WIDTH-1:0]   key_coef,
	input  logic [MOD_WIDTH-1:0]   body,
	input  logic                   last,
	input  logic [MOD_WIDTH-1:0]   modulus,
	input  logic                   cmd_full,
	output logic                   cmd_wr,
	output ldip_pkg::ldip_flags_t  cmd_flags,
	output logic [MOD_WIDTH-1:0]   cmd_mask,
	output logic [MOD_WIDTH-1:0]   cmd_key,
	output logic [MOD_WIDTH-1:0]   cmd_body
);
	import ldip_pkg::*;

	assign full   = cmd_full;
	assign cmd_wr = push && !cmd_full;

	// mark which operands still need a reduction pass in the back part
	always_comb begin
		cmd_flags.last     = last;
		cmd_flags.mask_big = (mask_coef >= modulus);
		cmd_flags.body_big = last && (body >= modulus);
	end

	assign cmd_mask = mask_coef;
	assign cmd_key  = key_coef;
	assign cmd_body = body;

endmodule

// ===== rtl/core/ldip_back.sv =====
module ldip_back #(
	parameter int MOD_WIDTH = ldip_pkg::MOD_WIDTH_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cmd_empty,
	output logic                                  cmd_pop,
	input  ldip_pkg::ldip_flags_t                 cmd_flags,
	input  logic [MOD_WIDTH-1:0]                  cmd_mask,
	input  logic [MOD_WIDTH-1:0]                  cmd_key,
	input  logic [MOD_WIDTH-1:0]                  cmd_body,
	input  logic [MOD_WIDTH-1:0]                  modulus,
	input  logic [ldip_pkg::PLAIN_WIDTH-1:0]      plain_modulus,
	input  logic                                  nand_mode,
	input  logic                                  res_full,
	output logic                                  res_push,
	output logic [ldip_pkg::MSG_WIDTH-1:0]        res_message
);
	import ldip_pkg::*;

	localparam int W    = MOD_WIDTH;
	localparam int PW   = PLAIN_WIDTH;
	localparam int CntW = ($clog2(W) > $clog2(PW)) ? $clog2(W) : $clog2(PW);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RED_ACC,
		S_RED_MASK,
		S_MAC,
		S_RED_BODY,
		S_DIV_P,
		S_ADD_OFF,
		S_SCALE,
		S_DIV_Q,
		S_EMIT
	} state_t;

	state_t          state_q;
	ldip_flags_t     flags_q;
	logic [W-1:0]    mask_q;
	logic [W-1:0]    key_q;
	logic [W-1:0]    body_q;
	logic [W-1:0]    acc_q;
	logic [W-1:0]    x_q;
	logic [W-1:0]    y_q;
	logic [W-1:0]    res_q;
	logic [W-1:0]    r_q;
	logic [W-1:0]    dq_q;
	logic [PW-1:0]   drem_q;
	logic [W-1:0]    rem_q;
	logic [PW-1:0]   lo_q;
	logic [CntW-1:0] cnt_q;

	logic            acc_big;
	logic            eng_done;
	logic [W-1:0]    eng_sum;
	logic [W-1:0]    eng_dbl;
	logic [PW:0]     div_trial;
	logic            div_bit;
	logic [PW:0]     div_rem;
	logic [W:0]      quot_trial;
	logic            quot_bit;
	logic [W:0]      quot_rem;
	logic [W-1:0]    offset;
	logic [PW-1:0]   mult_m;
	logic [W+PW-1:0] scaled;

	function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
	                                         input logic [W-1:0] q);
		logic [W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, q}) begin
			s = s - {1'b0, q};
		end
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] sub_mod(input logic [W-1:0] a, input logic [W-1:0] b,
	                                         input logic [W-1:0] q);
		return (a >= b) ? a - b : a - b + q;
	endfunction

	// shared modular unit, least significant bit of y first:
	// res += x when the bit is set, x doubles modulo q each step
	assign eng_done = (y_q == '0);
	assign eng_sum  = y_q[0] ? add_mod(res_q, x_q, modulus) : res_q;
	assign eng_dbl  = add_mod(x_q, x_q, modulus);
	assign acc_big  = (acc_q >= modulus);

	// restoring division of q by p for the rounding offset
	assign div_trial = {drem_q, dq_q[W-1]};
	assign div_bit   = (div_trial >= {1'b0, plain_modulus});
	assign div_rem   = div_bit ? div_trial - {1'b0, plain_modulus} : div_trial;

	// restoring division of m*r by q, nine quotient bits
	assign quot_trial = {rem_q, lo_q[PW-1]};
	assign quot_bit   = (quot_trial >= {1'b0, modulus});
	assign quot_rem   = quot_bit ? quot_trial - {1'b0, modulus} : quot_trial;

	assign offset = nand_mode ? dq_q : (dq_q >> 1);
	assign mult_m = nand_mode ? (plain_modulus >> 1) : plain_modulus;
	assign scaled = (W + PW)'(r_q) * (W + PW)'(mult_m);

	assign cmd_pop     = (state_q == S_IDLE) && !cmd_empty;
	assign res_push    = (state_q == S_EMIT) && !res_full;
	assign res_message = lo_q[MSG_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			acc_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						flags_q <= cmd_flags;
						mask_q  <= cmd_mask;
						key_q   <= cmd_key;
						body_q  <= cmd_body;
						x_q     <= W'(1);
						y_q     <= acc_big ? acc_q : '0;
						res_q   <= acc_big ? '0 : acc_q;
						state_q <= S_RED_ACC;
					end
				end
				S_RED_ACC: begin
					if (eng_done) begin
						acc_q   <= res_q;
						x_q     <= W'(1);
						y_q     <= flags_q.mask_big ? mask_q : '0;
						res_q   <= flags_q.mask_big ? '0 : mask_q;
						state_q <= S_RED_MASK;
					end else begin
						x_q   <= eng_dbl;
						y_q   <= y_q >> 1;
						res_q <= eng_sum;
					end
				end
				S_RED_MASK: begin
					if (eng_done) begin
						// multiply the reduced mask by the key on top of the accumulator
						x_q     <= res_q;
						y_q     <= key_q;
						res_q   <= acc_q;
						state_q <= S_MAC;
					end else begin
						x_q   <= eng_dbl;
						y_q   <= y_q >> 1;
						res_q <= eng_sum;
					end
				end
				S_MAC: begin
					if (eng_done) begin
						acc_q <= res_q;
						if (flags_q.last) begin
							x_q     <= W'(1);
							y_q     <= flags_q.body_big ? body_q : '0;
							res_q   <= flags_q.body_big ? '0 : body_q;
							state_q <= S_RED_BODY;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						x_q   <= eng_dbl;
						y_q   <= y_q >> 1;
						res_q <= eng_sum;
					end
				end
				S_RED_BODY: begin
					if (eng_done) begin
						r_q     <= sub_mod(res_q, acc_q, modulus);
						dq_q    <= modulus;
						drem_q  <= '0;
						cnt_q   <= CntW'(W - 1);
						state_q <= S_DIV_P;
					end else begin
						x_q   <= eng_dbl;
						y_q   <= y_q >> 1;
						res_q <= eng_sum;
					end
				end
				S_DIV_P: begin
					drem_q <= div_rem[PW-1:0];
					dq_q   <= {dq_q[W-2:0], div_bit};
					if (cnt_q == '0) begin
						state_q <= S_ADD_OFF;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_ADD_OFF: begin
					r_q     <= add_mod(r_q, offset, modulus);
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					{rem_q, lo_q} <= scaled;
					cnt_q         <= CntW'(PW - 1);
					state_q       <= S_DIV_Q;
				end
				S_DIV_Q: begin
					rem_q <= quot_rem[W-1:0];
					lo_q  <= {lo_q[PW-2:0], quot_bit};
					if (cnt_q == '0) begin
						state_q <= S_EMIT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_EMIT: begin
					// hold until the result queue has room
					if (!res_full) begin
						acc_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/lwe_decrypt_inner_product.sv =====
// Multi-key LWE decryption over a stream of coefficient pairs. Each request pushed in carries
// one mask coefficient and its key coefficient; the block keeps the running inner product
// modulo the ciphertext modulus q, and on the request marked last it also takes the body b,
// rounds b minus the inner product with q/(2p) (q/p in NAND mode) and pops out
// floor(p*r/q) (floor((p/2)*r/q) in NAND mode), then clears the accumulator. Requests pass
// through a two-deep command queue to a sequencer built round one modular double-and-add
// unit, and results wait in a two-deep result queue, so pushes continue while a result is
// not yet popped. The sequencer handles one request at a time: it reduces the accumulator and
// then the mask when either is not already below q, then adds the mask times the key to the
// accumulator, least significant key bit first. A last request then reduces the body when it
// is not below q, subtracts the sum, divides q by p for the rounding offset, adds it, scales
// and takes the nine quotient bits of the division by q. The user must write the registers
// through cfg_we/cfg_index/cfg_wdata only while no request is in flight; the block itself does
// not enforce it. q below two acts as two and p is clamped to the range two to 256.
module lwe_decrypt_inner_product #(
	parameter int  MOD_WIDTH = ldip_pkg::MOD_WIDTH_DEFAULT,
	localparam int CfgW = (MOD_WIDTH > ldip_pkg::PLAIN_WIDTH) ? MOD_WIDTH
	                                                          : ldip_pkg::PLAIN_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ldip_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [CfgW-1:0]                       cfg_wdata,
	input  logic                                  push,
	output logic                                  full,
	input  logic [MOD_WIDTH-1:0]                  mask_coef,
	input  logic [MOD_WIDTH-1:0]                  key_coef,
	input  logic [MOD_WIDTH-1:0]                  body,
	input  logic                                  last,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [ldip_pkg::MSG_WIDTH-1:0]        message
);
	import ldip_pkg::*;

	localparam int W    = MOD_WIDTH;
	localparam int FlgW = $bits(ldip_flags_t);
	localparam int CmdW = FlgW + 3 * W;

	logic [W-1:0]           cipher_modulus_q;
	logic [PLAIN_WIDTH-1:0] plain_modulus_q;
	logic                   nand_mode_q;
	logic [W-1:0]           q_eff;
	logic [PLAIN_WIDTH-1:0] p_eff;

	logic                   cmd_wr;
	logic                   cmd_full;
	logic                   cmd_empty;
	logic                   cmd_pop;
	ldip_flags_t            wr_flags;
	logic [W-1:0]           wr_mask;
	logic [W-1:0]           wr_key;
	logic [W-1:0]           wr_body;
	logic [CmdW-1:0]        cmd_wdata;
	logic [CmdW-1:0]        cmd_rdata;
	ldip_flags_t            rd_flags;
	logic [W-1:0]           rd_mask;
	logic [W-1:0]           rd_key;
	logic [W-1:0]           rd_body;

	logic                   res_push;
	logic                   res_full;
	logic [MSG_WIDTH-1:0]   res_message;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_modulus_q <= W'(CIPHER_MODULUS_RESET);
			plain_modulus_q  <= PLAIN_WIDTH'(PLAIN_MODULUS_RESET);
			nand_mode_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CIPHER_MODULUS: cipher_modulus_q <= cfg_wdata[W-1:0];
				CFG_PLAIN_MODULUS:  plain_modulus_q  <= cfg_wdata[PLAIN_WIDTH-1:0];
				CFG_NAND_MODE:      nand_mode_q      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		q_eff = (cipher_modulus_q < W'(CIPHER_MODULUS_MIN)) ? W'(CIPHER_MODULUS_MIN)
		                                                     : cipher_modulus_q;
		priority if (plain_modulus_q < PLAIN_WIDTH'(PLAIN_MODULUS_MIN)) begin
			p_eff = PLAIN_WIDTH'(PLAIN_MODULUS_MIN);
		end else if (plain_modulus_q > PLAIN_WIDTH'(PLAIN_MODULUS_MAX)) begin
			p_eff = PLAIN_WIDTH'(PLAIN_MODULUS_MAX);
		end else begin
			p_eff = plain_modulus_q;
		end
	end

	ldip_front #(.MOD_WIDTH(W)) u_front (
		.push      (push),
		.full      (full),
		.mask_coef (mask_coef),
		.key_coef  (key_coef),
		.body      (body),
		.last      (last),
		.modulus   (q_eff),
		.cmd_full  (cmd_full),
		.cmd_wr    (cmd_wr),
		.cmd_flags (wr_flags),
		.cmd_mask  (wr_mask),
		.cmd_key   (wr_key),
		.cmd_body  (wr_body)
	);

	assign cmd_wdata = {wr_flags, wr_mask, wr_key, wr_body};
	assign {rd_flags, rd_mask, rd_key, rd_body} = cmd_rdata;

	ldip_fifo #(.WIDTH(CmdW), .DEPTH(CMD_DEPTH)) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_wr),
		.wr_data (cmd_wdata),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rdata),
		.empty   (cmd_empty)
	);

	ldip_back #(.MOD_WIDTH(W)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_empty     (cmd_empty),
		.cmd_pop       (cmd_pop),
		.cmd_flags     (rd_flags),
		.cmd_mask      (rd_mask),
		.cmd_key       (rd_key),
		.cmd_body      (rd_body),
		.modulus       (q_eff),
		.plain_modulus (p_eff),
		.nand_mode     (nand_mode_q),
		.res_full      (res_full),
		.res_push      (res_push),
		.res_message   (res_message)
	);

	ldip_fifo #(.WIDTH(MSG_WIDTH), .DEPTH(RES_DEPTH)) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_message),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (message),
		.empty   (empty)
	);

`ifndef SYNTHESIS
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_push && res_full))
		else $error("result written into a full result queue");

	a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_pop && cmd_empty))
		else $error("request taken from an empty command queue");

	a_res_visible: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> !empty)
		else $error("written result not visible at the output");
`endif

endmodule

// ===== tb/lwe_decrypt_inner_product_tb.sv =====
`timescale 1ns / 100ps

module lwe_decrypt_inner_product_tb;
	import ldip_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 500;

	// Running inner product and expected messages, kept in step with accepted requests
	class decrypt_scoreboard;
		logic [31:0]          cipher_modulus;
		logic [8:0]           plain_modulus;
		logic                 nand_mode;
		logic [63:0]          inner_acc;
		logic [MSG_WIDTH-1:0] expected_messages[$];
		int                   errors;

		function new();
			cipher_modulus = CIPHER_MODULUS_RESET;
			plain_modulus  = 9'(PLAIN_MODULUS_RESET);
			nand_mode      = 1'b0;
			inner_acc      = '0;
			errors         = 0;
		endfunction

		function void write_register(ldip_cfg_index_t idx, logic [31:0] value);
			case (idx)
				CFG_CIPHER_MODULUS: cipher_modulus = value;
				CFG_PLAIN_MODULUS:  plain_modulus  = value[8:0];
				CFG_NAND_MODE:      nand_mode      = value[0];
				default: ;
			endcase
		endfunction

		function logic [63:0] eff_q();
			return (cipher_modulus < CIPHER_MODULUS_MIN) ? 64'(CIPHER_MODULUS_MIN)
			                                              : {32'b0, cipher_modulus};
		endfunction

		function logic [63:0] eff_p();
			if (plain_modulus < PLAIN_MODULUS_MIN)
				return 64'(PLAIN_MODULUS_MIN);
			if (plain_modulus > PLAIN_MODULUS_MAX)
				return 64'(PLAIN_MODULUS_MAX);
			return {55'b0, plain_modulus};
		endfunction

		function void note_request(logic [31:0] mask, logic [31:0] key, logic [31:0] b,
		                           logic is_last);
			logic [63:0] q, p, a, s, acc, r, scale, offset;
			q   = eff_q();
			p   = eff_p();
			a   = {32'b0, mask} % q;
			s   = {32'b0, key} % q;
			// the accumulator is reduced by the current modulus before each use
			acc = inner_acc % q;
			acc = (acc + (a * s) % q) % q;
			if (!is_last) begin
				inner_acc = acc;
				return;
			end
			r = ({32'b0, b} % q + q - acc) % q;
			if (nand_mode) begin
				scale  = p / 2;
				offset = q / p;
			end else begin
				scale  = p;
				offset = q / (p * 2);
			end
			r = (r + offset) % q;
			expected_messages.insert(expected_messages.size(), MSG_WIDTH'((scale * r) / q));
			inner_acc = '0;
		endfunction

		function void check_message(logic [MSG_WIDTH-1:0] actual);
			logic [MSG_WIDTH-1:0] want;
			if (expected_messages.size() == 0) begin
				$display("%0t: message with none waiting: expected none, actual %0d",
				         $time, actual);
				errors++;
				return;
			end
			want = expected_messages.pop_front();
			if (want !== actual) begin
				$display("%0t: message mismatch: expected %0d, actual %0d", $time, want, actual);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	ldip_cfg_index_t      cfg_index;
	logic [31:0]          cfg_wdata;
	logic                 push;
	logic                 full;
	logic [31:0]          mask_coef;
	logic [31:0]          key_coef;
	logic [31:0]          body;
	logic                 last;
	logic                 empty;
	logic                 pop;
	logic [MSG_WIDTH-1:0] message;

	int tx_idle_pct;
	int rx_idle_pct;
	int cycles;

	decrypt_scoreboard sb = new();

	lwe_decrypt_inner_product uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.mask_coef (mask_coef),
		.key_coef  (key_coef),
		.body      (body),
		.last      (last),
		.empty     (empty),
		.pop       (pop),
		.message   (message)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_message(message);
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(logic [31:0] mask, logic [31:0] key, logic [31:0] b,
	                            logic is_last);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push      <= 1'b1;
		mask_coef <= mask;
		key_coef  <= key;
		body      <= b;
		last      <= is_last;
		forever begin
			@(posedge clk);
			if (!full)
				break;
		end
		sb.note_request(mask, key, b, is_last);
		@(negedge clk);
	endtask

	// Drop push, drain all messages, then give the sequencer time to finish any
	// request that produces no message
	task automatic wait_idle();
		push <= 1'b0;
		while (sb.expected_messages.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_config(logic [31:0] q, logic [8:0] p, logic nand_sel);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CIPHER_MODULUS;
		cfg_wdata <= q;
		@(negedge clk);
		cfg_index <= CFG_PLAIN_MODULUS;
		cfg_wdata <= {23'b0, p};
		@(negedge clk);
		cfg_index <= CFG_NAND_MODE;
		cfg_wdata <= {31'b0, nand_sel};
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_register(CFG_CIPHER_MODULUS, q);
		sb.write_register(CFG_PLAIN_MODULUS, {23'b0, p});
		sb.write_register(CFG_NAND_MODE, {31'b0, nand_sel});
	endtask

	task automatic random_config();
		logic [31:0] q;
		logic [8:0]  p;
		case ($urandom_range(0, 7))
			0: q = $urandom_range(0, 1);
			1: q = $urandom_range(2, 3);
			2: q = 32'hffff_ffff;
			3: q = $urandom_range(4, 4096);
			4: q = 32'd1 << $urandom_range(2, 31);
			5: q = $urandom_range(32'h0010_0000, 32'h0100_0000);
			default: q = $urandom;
		endcase
		case ($urandom_range(0, 7))
			0: p = 9'($urandom_range(0, 1));
			1: p = 9'd2;
			2: p = 9'd256;
			3: p = 9'($urandom_range(257, 511));
			default: p = 9'($urandom_range(2, 256));
		endcase
		write_config(q, p, 1'($urandom_range(0, 1)));
	endtask

	// Mostly residues below q, with some unreduced and edge values mixed in
	function automatic logic [31:0] pick_value();
		logic [63:0] q;
		q = sb.eff_q();
		case ($urandom_range(0, 19))
			0:       return 32'd0;
			1:       return 32'(q - 1);
			2:       return 32'hffff_ffff;
			3, 4:    return $urandom;
			default: return 32'({32'b0, $urandom} % q);
		endcase
	endfunction

	task automatic run_random(int n);
		int sent, len, i;
		sent = 0;
		while (sent < n) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
			for (i = 0; i < len; i++) begin
				send_request(pick_value(), pick_value(), pick_value(), i == len - 1);
				sent++;
			end
		end
	endtask

	initial begin
		int seg, ph;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_CIPHER_MODULUS;
		cfg_wdata   = '0;
		push        = 1'b0;
		mask_coef   = '0;
		key_coef    = '0;
		body        = '0;
		last        = 1'b0;
		pop         = 1'b0;
		cycles      = 0;
		tx_idle_pct = 26;
		rx_idle_pct = 67;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: q = 1024, p = 4, normal mode
		send_request(32'd0, 32'd0, 32'd0, 1'b1);
		send_request(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
		send_request(32'd1023, 32'd1023, 32'd7, 1'b0);
		send_request(32'd5, 32'd7, 32'd500, 1'b1);
		wait_idle();
		// q below two acts as two; odd p in NAND mode
		write_config(32'd0, 9'd3, 1'b1);
		send_request(32'd1, 32'd1, 32'd1, 1'b1);
		send_request(32'hffff_ffff, 32'd1, 32'd0, 1'b0);
		send_request(32'd0, 32'd0, 32'hffff_ffff, 1'b1);
		wait_idle();
		write_config(32'd1, 9'd0, 1'b0);
		send_request(32'd1, 32'd0, 32'd1, 1'b1);
		wait_idle();
		write_config(32'hffff_ffff, 9'd256, 1'b0);
		send_request(32'hffff_fffe, 32'hffff_fffe, 32'd0, 1'b0);
		send_request(32'hffff_ffff, 32'd2, 32'hffff_fffe, 1'b1);
		send_request(32'd0, 32'd0, 32'h7fff_ffff, 1'b1);
		wait_idle();
		// p above 256 clamps
		write_config(32'hffff_ffff, 9'd511, 1'b1);
		send_request(32'h1234_5678, 32'h9abc_def0, 32'h8000_0000, 1'b1);
		wait_idle();
		write_config(32'd65537, 9'd257, 1'b0);
		send_request(32'd123456789, 32'd987654321, 32'd0, 1'b0);
		// change q with a partial sum held
		wait_idle();
		write_config(32'd1000, 9'd2, 1'b1);
		send_request(32'd3, 32'd5, 32'd999, 1'b1);
		wait_idle();
		write_config(32'd3, 9'd2, 1'b0);
		send_request(32'd2, 32'd2, 32'd0, 1'b1);

		for (seg = 0; seg < 3; seg++) begin
			case (seg)
				0: begin
					tx_idle_pct = 26;
					rx_idle_pct = 67;
				end
				1: begin
					tx_idle_pct = 67;
					rx_idle_pct = 26;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (ph = 0; ph < 4; ph++) begin
				wait_idle();
				random_config();
				run_random(100);
			end
		end

		wait_idle();
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
